// ===== hdl/wswm_pkg.sv =====
// wswm_pkg: shared types, widths and constants of the working-set window monitor.
// Used by wswm_ctrl, wswm_datapath, working_set_window_monitor and its testbench.
`default_nettype none

package wswm_pkg;

    localparam int ADDR_W      = 32;
    localparam int PSL_W       = 5;
    localparam int WL_W        = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;
    localparam int WNUM_W      = 16;
    localparam int WSS_W       = 6;
    localparam int TOT_W       = 9;
    localparam int M_TDATA_W   = WNUM_W + WSS_W + TOT_W + 1;

    localparam int WINDOW_MAX_DEF = 32;
    localparam int TOTAL_MAX_DEF  = 256;
    localparam int ADDR_BITS_DEF  = 32;

    localparam logic [PSL_W-1:0] PSL_RESET = 5'd12;
    localparam logic [WL_W-1:0]  WL_RESET  = 6'd16;
    localparam logic [PSL_W-1:0] MIN_SHIFT = 5'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE_LOG2 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_CHECK,
        ST_CLOSE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
        logic close;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic close_due;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/wswm_ram.sv =====
// wswm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wswm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/wswm_ctrl.sv =====
// wswm_ctrl: sequencer of the working-set window monitor.
// Depends on wswm_pkg; drives commands to wswm_datapath from its status.
`default_nettype none

module wswm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tuser,
    output logic                   s_tready,
    input  wire wswm_pkg::status_t status,
    output wswm_pkg::cmd_t         cmd
);

    wswm_pkg::state_t state_reg;
    wswm_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wswm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            wswm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = s_tuser ? wswm_pkg::ST_CLOSE : wswm_pkg::ST_SCAN;
                end
            end
            wswm_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = wswm_pkg::ST_UPDATE;
                end
            end
            wswm_pkg::ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = wswm_pkg::ST_CHECK;
            end
            wswm_pkg::ST_CHECK: begin
                state_next = status.close_due ? wswm_pkg::ST_CLOSE : wswm_pkg::ST_IDLE;
            end
            wswm_pkg::ST_CLOSE: begin
                if (status.out_free) begin
                    cmd.close  = 1'b1;
                    state_next = wswm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wswm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/wswm_datapath.sv =====
// wswm_datapath: configuration, page stores, sequential search, counters and result register.
// Depends on wswm_pkg and wswm_ram; commanded by wswm_ctrl.
`default_nettype none

module wswm_datapath #(
    parameter int WINDOW_MAX = wswm_pkg::WINDOW_MAX_DEF,
    parameter int TOTAL_MAX  = wswm_pkg::TOTAL_MAX_DEF,
    parameter int ADDR_BITS  = wswm_pkg::ADDR_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [wswm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [wswm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic [wswm_pkg::ADDR_W-1:0]         s_tdata,
    input  wire logic                                s_tuser,
    input  wire wswm_pkg::cmd_t                      cmd,
    output wswm_pkg::status_t                        status,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [wswm_pkg::M_TDATA_W-1:0]           m_tdata,
    output logic                                     m_tuser
);

    localparam int EFF_ADDR = (ADDR_BITS < wswm_pkg::ADDR_W) ? ADDR_BITS : wswm_pkg::ADDR_W;
    localparam int PAGE_W   = EFF_ADDR - 2;
    localparam int WF_W     = $clog2(WINDOW_MAX + 1);
    localparam int TF_W     = $clog2(TOTAL_MAX + 1);
    localparam int WA_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int TA_W     = (TOTAL_MAX > 1) ? $clog2(TOTAL_MAX) : 1;
    localparam int SCAN_W   = (WF_W > TF_W) ? WF_W : TF_W;
    localparam int LEN_W    = (WF_W > wswm_pkg::WL_W) ? WF_W : wswm_pkg::WL_W;
    localparam logic [wswm_pkg::ADDR_W-1:0] ADDR_MASK =
        (EFF_ADDR >= wswm_pkg::ADDR_W) ? {wswm_pkg::ADDR_W{1'b1}} :
        ((wswm_pkg::ADDR_W)'(1) << EFF_ADDR) - (wswm_pkg::ADDR_W)'(1);

    logic [wswm_pkg::PSL_W-1:0]  psl_reg, psl_next;
    logic [wswm_pkg::WL_W-1:0]   wl_reg, wl_next;
    logic [WF_W-1:0]             wfill_reg, wfill_next;
    logic [TF_W-1:0]             tfill_reg, tfill_next;
    logic [WF_W-1:0]             acc_reg, acc_next;
    logic [wswm_pkg::WNUM_W-1:0] wcnt_reg, wcnt_next;
    logic                        ovf_reg, ovf_next;
    logic                        pend_reg, pend_next;
    logic                        out_valid_reg, out_valid_next;
    logic [SCAN_W-1:0]           idx_reg, idx_next;

    logic [PAGE_W-1:0]           page_reg, page_next;
    logic                        finish_reg, finish_next;
    logic [SCAN_W-1:0]           rd_idx_reg, rd_idx_next;
    logic                        wfound_reg, wfound_next;
    logic                        tfound_reg, tfound_next;
    logic [wswm_pkg::WNUM_W-1:0] out_num_reg, out_num_next;
    logic [wswm_pkg::WSS_W-1:0]  out_ws_reg, out_ws_next;
    logic [wswm_pkg::TOT_W-1:0]  out_tot_reg, out_tot_next;
    logic                        out_full_reg, out_full_next;
    logic                        out_fin_reg, out_fin_next;

    logic [wswm_pkg::PSL_W-1:0]  shift;
    logic [wswm_pkg::ADDR_W-1:0] addr_shifted;
    logic [LEN_W-1:0]            eff_len;
    logic [SCAN_W-1:0]           scan_limit;
    logic                        w_we, t_we;
    logic [PAGE_W-1:0]           w_q, t_q;

    assign shift        = (psl_reg < wswm_pkg::MIN_SHIFT) ? wswm_pkg::MIN_SHIFT : psl_reg;
    assign addr_shifted = (s_tdata & ADDR_MASK) >> shift;

    always_comb begin
        eff_len = LEN_W'(wl_reg);
        if (wl_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (eff_len > LEN_W'(WINDOW_MAX)) begin
            eff_len = LEN_W'(WINDOW_MAX);
        end
    end

    assign scan_limit = (SCAN_W'(wfill_reg) > SCAN_W'(tfill_reg)) ?
                        SCAN_W'(wfill_reg) : SCAN_W'(tfill_reg);

    assign w_we = cmd.update && !wfound_reg && (wfill_reg < WF_W'(WINDOW_MAX));
    assign t_we = cmd.update && !tfound_reg && (tfill_reg < TF_W'(TOTAL_MAX));

    wswm_ram #(.WIDTH(PAGE_W), .DEPTH(WINDOW_MAX)) u_window_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (wfill_reg[WA_W-1:0]),
        .wdata (page_reg),
        .raddr (idx_reg[WA_W-1:0]),
        .rdata (w_q)
    );

    wswm_ram #(.WIDTH(PAGE_W), .DEPTH(TOTAL_MAX)) u_total_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (tfill_reg[TA_W-1:0]),
        .wdata (page_reg),
        .raddr (idx_reg[TA_W-1:0]),
        .rdata (t_q)
    );

    always_comb begin
        psl_next       = psl_reg;
        wl_next        = wl_reg;
        wfill_next     = wfill_reg;
        tfill_next     = tfill_reg;
        acc_next       = acc_reg;
        wcnt_next      = wcnt_reg;
        ovf_next       = ovf_reg;
        pend_next      = pend_reg;
        idx_next       = idx_reg;
        page_next      = page_reg;
        finish_next    = finish_reg;
        rd_idx_next    = rd_idx_reg;
        wfound_next    = wfound_reg;
        tfound_next    = tfound_reg;
        out_num_next   = out_num_reg;
        out_ws_next    = out_ws_reg;
        out_tot_next   = out_tot_reg;
        out_full_next  = out_full_reg;
        out_fin_next   = out_fin_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (cfg_we) begin
            unique case (cfg_index)
                wswm_pkg::REG_PAGE_SIZE_LOG2: psl_next = cfg_wdata[wswm_pkg::PSL_W-1:0];
                wswm_pkg::REG_WINDOW_LENGTH:  wl_next  = cfg_wdata[wswm_pkg::WL_W-1:0];
                default: ;
            endcase
        end

        if (cmd.load) begin
            page_next   = addr_shifted[PAGE_W-1:0];
            finish_next = s_tuser;
            idx_next    = '0;
            pend_next   = 1'b0;
            wfound_next = 1'b0;
            tfound_next = 1'b0;
        end

        if (cmd.scan) begin
            if (pend_reg) begin
                if (rd_idx_reg < SCAN_W'(wfill_reg) && w_q == page_reg) begin
                    wfound_next = 1'b1;
                end
                if (rd_idx_reg < SCAN_W'(tfill_reg) && t_q == page_reg) begin
                    tfound_next = 1'b1;
                end
            end
            if (idx_reg < scan_limit) begin
                pend_next   = 1'b1;
                rd_idx_next = idx_reg;
                idx_next    = idx_reg + SCAN_W'(1);
            end else begin
                pend_next = 1'b0;
            end
        end

        if (cmd.update) begin
            if (w_we) begin
                wfill_next = wfill_reg + WF_W'(1);
            end
            if (t_we) begin
                tfill_next = tfill_reg + TF_W'(1);
            end else if (!tfound_reg) begin
                ovf_next = 1'b1;
            end
            acc_next = acc_reg + WF_W'(1);
        end

        if (cmd.close) begin
            out_valid_next = 1'b1;
            out_num_next   = wcnt_reg;
            out_ws_next    = wswm_pkg::WSS_W'(wfill_reg);
            out_tot_next   = wswm_pkg::TOT_W'(tfill_reg);
            out_full_next  = ovf_reg;
            out_fin_next   = finish_reg;
            if (wcnt_reg != {wswm_pkg::WNUM_W{1'b1}}) begin
                wcnt_next = wcnt_reg + wswm_pkg::WNUM_W'(1);
            end
            wfill_next = '0;
            acc_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psl_reg       <= wswm_pkg::PSL_RESET;
            wl_reg        <= wswm_pkg::WL_RESET;
            wfill_reg     <= '0;
            tfill_reg     <= '0;
            acc_reg       <= '0;
            wcnt_reg      <= '0;
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            psl_reg       <= psl_next;
            wl_reg        <= wl_next;
            wfill_reg     <= wfill_next;
            tfill_reg     <= tfill_next;
            acc_reg       <= acc_next;
            wcnt_reg      <= wcnt_next;
            ovf_reg       <= ovf_next;
            pend_reg      <= pend_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg     <= page_next;
        finish_reg   <= finish_next;
        rd_idx_reg   <= rd_idx_next;
        wfound_reg   <= wfound_next;
        tfound_reg   <= tfound_next;
        out_num_reg  <= out_num_next;
        out_ws_reg   <= out_ws_next;
        out_tot_reg  <= out_tot_next;
        out_full_reg <= out_full_next;
        out_fin_reg  <= out_fin_next;
    end

    assign status.scan_done = !pend_reg && (idx_reg >= scan_limit);
    assign status.close_due = LEN_W'(acc_reg) >= eff_len;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_full_reg, out_tot_reg, out_ws_reg, out_num_reg};
    assign m_tuser  = out_fin_reg;

endmodule

`default_nettype wire

// ===== hdl/working_set_window_monitor.sv =====
// Working-set window monitor: counts distinct pages per window of accesses and since reset.
// Sequence: an access is loaded, both stores are searched one entry a cycle up to the larger
// fill, the stores are updated and the window length is checked; a due window then closes
// once the result register is free, and a held result stalls it. A finish item is loaded and
// closes it the same way. One item is in work at a time. Reset: synchronous, active low;
// counters, fills and flags clear, stores keep contents. Depends on wswm_ctrl, wswm_datapath.
`default_nettype none

module working_set_window_monitor #(
    parameter int WINDOW_MAX = wswm_pkg::WINDOW_MAX_DEF,
    parameter int TOTAL_MAX  = wswm_pkg::TOTAL_MAX_DEF,
    parameter int ADDR_BITS  = wswm_pkg::ADDR_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [wswm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wswm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [wswm_pkg::ADDR_W-1:0]     s_tdata,   // address
    input  wire logic                            s_tuser,   // action
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [wswm_pkg::M_TDATA_W-1:0]       m_tdata,   // window_number, working_set_size,
                                                            // total_pages, total_full
    output logic                                 m_tuser    // from_finish
);

    wswm_pkg::cmd_t    cmd;
    wswm_pkg::status_t status;

    wswm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wswm_datapath #(
        .WINDOW_MAX (WINDOW_MAX),
        .TOTAL_MAX  (TOTAL_MAX),
        .ADDR_BITS  (ADDR_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    a_ready_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> s_tready)
        else $error("input not ready after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    a_access_window_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[wswm_pkg::WNUM_W +: wswm_pkg::WSS_W] != '0)
        else $error("window closed by access reports no pages");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_working_set_window_monitor.sv =====
// Testbench of working_set_window_monitor: streams access and finish items and checks every
// window report against a cycle-free predictor of the page stores and counters.
// Depends on wswm_pkg and the working_set_window_monitor RTL only.
`default_nettype none

module tb_working_set_window_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    import wswm_pkg::*;

    localparam int WIN_CAP       = WINDOW_MAX_DEF;
    localparam int TOT_CAP       = TOTAL_MAX_DEF;
    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int BURST_FINISH  = 40;

    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam int IDLE_NONE   = 0;
    localparam int IDLE_RANDOM = 1;
    localparam int IDLE_SPARSE = 2;

    typedef struct {
        logic        act;
        logic [31:0] addr;
        int          gap;
    } access_item_t;

    typedef struct packed {
        logic [WNUM_W-1:0] window_number;
        logic [WSS_W-1:0]  ws_size;
        logic [TOT_W-1:0]  total_pages;
        logic              total_full;
        logic              from_finish;
    } window_report_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [ADDR_W-1:0]     s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    working_set_window_monitor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // predicted block state
    logic [PSL_W-1:0] shadow_psl;
    logic [WL_W-1:0]  shadow_wl;
    logic [31:0]      window_pages [WIN_CAP];
    logic [31:0]      seen_pages [TOT_CAP];
    int               window_fill;
    int               seen_fill;
    int               window_accesses;
    logic [WNUM_W-1:0] window_index;
    logic             seen_overflow;

    access_item_t     pending_items[$];
    window_report_t   expected_reports[$];
    access_item_t     next_item;
    int               items_queued   = 0;
    int               items_accepted = 0;
    int               mismatches     = 0;
    int               idle_mode      = IDLE_NONE;
    int               ready_hold     = 0;
    int               quiet_cycles   = 0;
    logic [31:0]      addr_pool [64];
    int               pool_size;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int draw_wait();
        case (idle_mode)
            IDLE_RANDOM: return $urandom_range(0, 16);
            IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
            default:     return 0;
        endcase
    endfunction

    function automatic int page_shift();
        return (shadow_psl < MIN_SHIFT) ? int'(MIN_SHIFT) : int'(shadow_psl);
    endfunction

    function automatic int window_limit();
        int lim;
        lim = int'(shadow_wl);
        if (lim == 0) lim = 1;
        if (lim > WIN_CAP) lim = WIN_CAP;
        return lim;
    endfunction

    task automatic close_window(input logic fin);
        window_report_t rep;
        rep.window_number = window_index;
        rep.ws_size       = WSS_W'(window_fill);
        rep.total_pages   = TOT_W'(seen_fill);
        rep.total_full    = seen_overflow;
        rep.from_finish   = fin;
        expected_reports.push_back(rep);
        if (window_index != '1) window_index++;
        window_fill     = 0;
        window_accesses = 0;
    endtask

    task automatic account_item(input logic act, input logic [31:0] addr);
        logic [31:0] page;
        bit          hit;
        if (act == ACT_FINISH) begin
            close_window(1'b1);
            return;
        end
        page = addr >> page_shift();
        hit = 0;
        for (int i = 0; i < window_fill; i++) if (window_pages[i] == page) hit = 1;
        if (!hit && window_fill < WIN_CAP) begin
            window_pages[window_fill] = page;
            window_fill++;
        end
        hit = 0;
        for (int i = 0; i < seen_fill; i++) if (seen_pages[i] == page) hit = 1;
        if (!hit) begin
            if (seen_fill < TOT_CAP) begin
                seen_pages[seen_fill] = page;
                seen_fill++;
            end else begin
                seen_overflow = 1'b1;
            end
        end
        window_accesses++;
        if (window_accesses >= window_limit()) close_window(1'b0);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                account_item(s_tuser, s_tdata);
                items_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (pending_items[0].gap > 0) begin
                    pending_items[0].gap--;
                    s_tvalid <= 1'b0;
                end else begin
                    next_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.addr;
                    s_tuser  <= next_item.act;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        window_report_t got;
        window_report_t want;
        int             hold;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[21:16], m_tdata[30:22], m_tdata[31], m_tuser};
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected report: win %0d wss %0d tot %0d full %0b fin %0b",
                                 got.window_number, got.ws_size, got.total_pages,
                                 got.total_full, got.from_finish);
                end else begin
                    want = expected_reports.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"report mismatch: exp win %0d wss %0d tot %0d ",
                                      "full %0b fin %0b, got win %0d wss %0d tot %0d ",
                                      "full %0b fin %0b"},
                                     want.window_number, want.ws_size, want.total_pages,
                                     want.total_full, want.from_finish,
                                     got.window_number, got.ws_size, got.total_pages,
                                     got.total_full, got.from_finish);
                    end
                end
                hold = draw_wait();
                ready_hold <= hold;
                m_tready   <= (hold == 0);
            end else if (!m_tready) begin
                if (ready_hold <= 1) begin
                    ready_hold <= 0;
                    m_tready   <= 1'b1;
                end else begin
                    ready_hold <= ready_hold - 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("working_set_window_monitor verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_item(input logic act, input logic [31:0] addr);
        access_item_t it;
        it.act  = act;
        it.addr = addr;
        it.gap  = draw_wait();
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic wait_idle();
        while (items_accepted != items_queued || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [PSL_W-1:0] psl, input logic [WL_W-1:0] wl);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PAGE_SIZE_LOG2;
        cfg_wdata <= CFG_DATA_W'(psl);
        shadow_psl = psl;
        @(posedge aclk);
        cfg_index <= REG_WINDOW_LENGTH;
        cfg_wdata <= wl;
        shadow_wl = wl;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_random_phase(input int count);
        logic [31:0] addr;
        logic [31:0] low_mask;
        int          pick;
        pool_size = $urandom_range(2, 40);
        for (int i = 0; i < pool_size; i++) addr_pool[i] = $urandom;
        low_mask = (32'd1 << page_shift()) - 32'd1;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 7) begin
                queue_item(ACT_FINISH, $urandom);
            end else if (pick < 85) begin
                addr = addr_pool[$urandom_range(0, pool_size - 1)];
                addr = (addr & ~low_mask) | ($urandom & low_mask);
                queue_item(ACT_ACCESS, addr);
            end else begin
                queue_item(ACT_ACCESS, $urandom);
            end
        end
    endtask

    initial begin
        logic [PSL_W-1:0] psl_pick;
        logic [WL_W-1:0]  wl_pick;
        shadow_psl      = PSL_RESET;
        shadow_wl       = WL_RESET;
        window_fill     = 0;
        seen_fill       = 0;
        window_accesses = 0;
        window_index    = '0;
        seen_overflow   = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // empty window on finish, page folding, address extremes
        idle_mode = IDLE_RANDOM;
        queue_item(ACT_FINISH, 32'h0);
        queue_item(ACT_ACCESS, 32'h0000_0000);
        queue_item(ACT_ACCESS, 32'h0000_0FFF);
        queue_item(ACT_ACCESS, 32'hFFFF_FFFF);
        queue_item(ACT_ACCESS, 32'h0000_1000);
        queue_item(ACT_ACCESS, 32'h0000_0000);
        queue_item(ACT_FINISH, 32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++) queue_item(ACT_ACCESS, 32'h0001_0000 * i);
        wait_idle();

        // shorten the window below the accesses already taken
        set_regs(5'd12, 6'd2);
        queue_item(ACT_ACCESS, 32'h0004_0000);
        wait_idle();

        // shift below minimum, zero length
        set_regs(5'd0, 6'd0);
        queue_item(ACT_ACCESS, 32'h0000_0003);
        queue_item(ACT_ACCESS, 32'h0000_0004);
        queue_item(ACT_ACCESS, 32'h8000_0000);
        wait_idle();

        // widest shift, length above the window store
        set_regs(5'd31, 6'd63);
        queue_item(ACT_ACCESS, 32'h7FFF_FFFF);
        queue_item(ACT_ACCESS, 32'h8000_0000);
        queue_item(ACT_FINISH, 32'h0);
        wait_idle();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0:       begin psl_pick = 5'd2;  wl_pick = 6'd1;  end
                1:       begin psl_pick = 5'd16; wl_pick = 6'd32; end
                2:       begin psl_pick = 5'd12; wl_pick = 6'd16; end
                3:       begin psl_pick = 5'd1;  wl_pick = 6'd33; end
                4:       begin psl_pick = 5'd31; wl_pick = 6'd0;  end
                default: begin
                    psl_pick = ($urandom_range(0, 5) == 0) ? 5'($urandom)
                                                           : 5'($urandom_range(2, 16));
                    wl_pick  = ($urandom_range(0, 5) == 0) ? 6'($urandom)
                                                           : 6'($urandom_range(1, 32));
                end
            endcase
            idle_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            set_regs(psl_pick, wl_pick);
            queue_random_phase(100);
            wait_idle();
        end

        // back-to-back finish items, then single-access windows
        idle_mode = IDLE_NONE;
        for (int n = 0; n < BURST_FINISH; n++) queue_item(ACT_FINISH, 32'h0);
        wait_idle();
        set_regs(5'd2, 6'd1);
        idle_mode = IDLE_RANDOM;
        for (int n = 0; n < 4; n++) queue_item(ACT_ACCESS, $urandom);
        queue_item(ACT_FINISH, 32'h0);
        wait_idle();

        if (mismatches == 0)
            $display("working_set_window_monitor verification clean");
        else
            $display("working_set_window_monitor verification failed");
        $finish;
    end

endmodule

`default_nettype wire
